// ===== hdl/pba_pkg.sv =====
// Shared types and constants for the page bitmap allocator.
// Used by the word unit, the top level and the checker; no dependencies of its own.
package pba_pkg;

  localparam int unsigned MAX_PAGES = 65536;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned N_WORDS   = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int unsigned ADDR_W    = (N_WORDS > 1) ? $clog2(N_WORDS) : 1;
  localparam int unsigned BIT_W     = $clog2(WORD_W);
  // page arithmetic width: holds any page, the limit and index + count
  localparam int unsigned PW        = (ADDR_W + BIT_W + 1 > 18) ? ADDR_W + BIT_W + 1 : 18;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned CNT_W     = 17;
  localparam int unsigned IN_DW     = 40;
  localparam int unsigned OUT_DW    = 72;

  localparam logic [CNT_W-1:0] TOTAL_RST = 17'h10000;

  typedef enum logic [CMD_W-1:0] {
    CMD_REQUEST   = 3'd0,
    CMD_FREE      = 3'd1,
    CMD_LOCK      = 3'd2,
    CMD_RESERVE   = 3'd3,
    CMD_UNRESERVE = 3'd4
  } cmd_e;

  typedef struct packed {
    logic             search;
    logic             target;
    logic             is_first;
    logic             is_last;
    logic [BIT_W-1:0] fbit;
    logic [BIT_W-1:0] lbit;
  } word_ctl_t;

  typedef struct packed {
    logic [WORD_W-1:0] wdata;
    logic [BIT_W:0]    flips;
    logic              hit;
    logic [BIT_W-1:0]  hit_bit;
  } word_res_t;

endpackage

// ===== hdl/pba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pba_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/pba_word_unit.sv =====
// Per-word datapath: run mask, bit flips, popcount and first-free search.
// Depends on pba_pkg.
module pba_word_unit (
  input  pba_pkg::word_ctl_t           ctl_i,
  input  logic [pba_pkg::WORD_W-1:0]   rdata_i,
  output pba_pkg::word_res_t           res_o
);
  import pba_pkg::*;

  logic [WORD_W-1:0] lo_mask;
  logic [WORD_W-1:0] hi_mask;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] flip;
  logic [WORD_W-1:0] low1;
  logic [BIT_W:0]    pc;
  logic [BIT_W-1:0]  idx;

  always_comb begin
    lo_mask = ctl_i.is_first ? ({WORD_W{1'b1}} << ctl_i.fbit) : {WORD_W{1'b1}};
    hi_mask = ctl_i.is_last ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - ctl_i.lbit))
                            : {WORD_W{1'b1}};
    mask = lo_mask & hi_mask;
    // bits in the window that differ from the target state
    flip = ctl_i.target ? (~rdata_i & mask) : (rdata_i & mask);
    low1 = flip & (~flip + WORD_W'(1));
    pc   = '0;
    for (int i = 0; i < WORD_W; i++) begin
      pc = pc + (BIT_W + 1)'(flip[i]);
    end
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (flip[i]) begin
        idx = BIT_W'(i);
      end
    end
    res_o.hit     = |flip;
    res_o.hit_bit = idx;
    res_o.flips   = pc;
    res_o.wdata   = ctl_i.search ? (rdata_i | low1) : (rdata_i ^ flip);
  end

endmodule

// ===== hdl/page_bitmap_allocator_unit.sv =====
// Page bitmap allocator top level: bitmap RAM walk, counters and stream ports.
// Accept to result valid: a request walks the words up to the first free page, run ops walk
// the words spanned by the run; empty runs and unknown commands skip the walk.
// Items are handled one at a time; the next is accepted once the result is loaded, later while a result stalls.
// Reset: counters clear, total_pages = 65536, then a clearing pass over all N_WORDS
// (1024) words zeroes the bitmap while s_axis_tready is held low.
module page_bitmap_allocator_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pba_pkg::CNT_W-1:0]    cfg_wdata_i,     // total_pages
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [15:0] page_index, [32:16] page_count, [39:33] zero
  input  logic [pba_pkg::IN_DW-1:0]    s_axis_tdata,
  input  logic [pba_pkg::CMD_W-1:0]    s_axis_tuser,    // command
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [15:0] granted_page, [32:16] free_pages, [49:33] used_pages,
  // [66:50] reserved_pages, [71:67] zero
  output logic [pba_pkg::OUT_DW-1:0]   m_axis_tdata,
  output logic                         m_axis_tuser     // found
);
  import pba_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  total_q, used_q, used_d, resv_q, resv_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [ADDR_W-1:0] first_w_q, first_w_d, last_w_q, last_w_d, dw_q, dw_d;
  logic [BIT_W-1:0]  fbit_q, fbit_d, lbit_q, lbit_d;
  logic [ADDR_W:0]   iss_q, iss_d;
  logic              rdv_q, rdv_d;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  grant_q, grant_d;

  logic              out_vld_q, out_vld_d;
  logic              out_found_q;
  logic [IDX_W-1:0]  out_grant_q;
  logic [CNT_W-1:0]  out_free_q, out_used_q, out_resv_q;
  logic              out_load;

  // RAM side
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  word_ctl_t         wctl;
  word_res_t         wres;

  // start-of-item decode
  logic [PW-1:0]     lim, idx_x, end_x, endc, s_first, s_end, last_pg;
  logic              in_acc, cmd_ok, is_search;

  always_comb begin
    lim     = (32'(total_q) < MAX_PAGES) ? PW'(total_q) : PW'(MAX_PAGES);
    idx_x   = PW'(s_axis_tdata[IDX_W-1:0]);
    end_x   = idx_x + PW'(s_axis_tdata[IDX_W +: CNT_W]);
    endc    = (end_x < lim) ? end_x : lim;
    is_search = (s_axis_tuser == CMD_REQUEST);
    s_first = is_search ? '0 : idx_x;
    s_end   = is_search ? lim : endc;
    last_pg = s_end - PW'(1);
    cmd_ok  = s_axis_tuser inside {[CMD_REQUEST:CMD_UNRESERVE]};
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  assign wctl.search   = (cmd_q == CMD_REQUEST);
  assign wctl.target   = (cmd_q == CMD_REQUEST) || (cmd_q == CMD_LOCK)
                      || (cmd_q == CMD_RESERVE);
  assign wctl.is_first = (dw_q == first_w_q);
  assign wctl.is_last  = (dw_q == last_w_q);
  assign wctl.fbit     = fbit_q;
  assign wctl.lbit     = lbit_q;

  pba_word_unit u_word (
    .ctl_i   (wctl),
    .rdata_i (ram_rdata),
    .res_o   (wres)
  );

  pba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (N_WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cmd_d     = cmd_q;
    first_w_d = first_w_q;
    last_w_d  = last_w_q;
    fbit_d    = fbit_q;
    lbit_d    = lbit_q;
    iss_d     = iss_q;
    dw_d      = dw_q;
    rdv_d     = 1'b0;
    found_d   = found_q;
    grant_d   = grant_q;
    used_d    = used_q;
    resv_d    = resv_q;
    ram_we    = 1'b0;
    ram_waddr = dw_q;
    ram_wdata = wres.wdata;
    ram_re    = 1'b0;
    ram_raddr = iss_q[ADDR_W-1:0];
    out_load  = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + ADDR_W'(1);
        if (32'(clr_q) == N_WORDS - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d     = s_axis_tuser;
          found_d   = 1'b0;
          grant_d   = '0;
          first_w_d = s_first[BIT_W +: ADDR_W];
          fbit_d    = s_first[BIT_W-1:0];
          last_w_d  = last_pg[BIT_W +: ADDR_W];
          lbit_d    = last_pg[BIT_W-1:0];
          iss_d     = {1'b0, s_first[BIT_W +: ADDR_W]};
          if (!cmd_ok || (s_end <= s_first)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // issue reads one word ahead of the returning data
        if (iss_q <= {1'b0, last_w_q}) begin
          ram_re = 1'b1;
          rdv_d  = 1'b1;
          dw_d   = iss_q[ADDR_W-1:0];
          iss_d  = iss_q + (ADDR_W + 1)'(1);
        end
        if (rdv_q) begin
          if (wctl.search) begin
            if (wres.hit) begin
              ram_we  = 1'b1;
              found_d = 1'b1;
              grant_d = IDX_W'(PW'({dw_q, wres.hit_bit}));
              used_d  = used_q + CNT_W'(1);
              state_d = ST_DONE;
            end else if (wctl.is_last) begin
              state_d = ST_DONE;
            end
          end else begin
            ram_we = 1'b1;
            case (cmd_q)
              CMD_FREE:      used_d = used_q - CNT_W'(wres.flips);
              CMD_LOCK:      used_d = used_q + CNT_W'(wres.flips);
              CMD_RESERVE:   resv_d = resv_q + CNT_W'(wres.flips);
              CMD_UNRESERVE: resv_d = resv_q - CNT_W'(wres.flips);
              default:       ;
            endcase
            if (wctl.is_last) begin
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      total_q   <= TOTAL_RST;
      used_q    <= '0;
      resv_q    <= '0;
      rdv_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      used_q    <= used_d;
      resv_q    <= resv_d;
      rdv_q     <= rdv_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    first_w_q <= first_w_d;
    last_w_q  <= last_w_d;
    fbit_q    <= fbit_d;
    lbit_q    <= lbit_d;
    iss_q     <= iss_d;
    dw_q      <= dw_d;
    found_q   <= found_d;
    grant_q   <= grant_d;
    if (out_load) begin
      out_found_q <= found_q;
      out_grant_q <= grant_q;
      out_free_q  <= total_q - used_q - resv_q;
      out_used_q  <= used_q;
      out_resv_q  <= resv_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = {5'b0, out_resv_q, out_used_q, out_free_q, out_grant_q};

endmodule

// ===== hdl/pba_checker.sv =====
// Port-level checks for the page bitmap allocator, bound to the top level.
// Depends on pba_pkg and page_bitmap_allocator_unit.
module pba_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_we_i,
  input logic [pba_pkg::CNT_W-1:0]    cfg_wdata_i,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [pba_pkg::OUT_DW-1:0]   m_axis_tdata,
  input logic                         m_axis_tuser
);
  import pba_pkg::*;

  logic [CNT_W-1:0] total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_RST;
    end else if (cfg_we_i) begin
      total_q <= cfg_wdata_i;
    end
  end

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:0] == 16'd0)
    else $error("granted_page non-zero without found");

  a_free_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      m_axis_tdata[32:16] == CNT_W'(total_q - m_axis_tdata[49:33] - m_axis_tdata[66:50]))
    else $error("free_pages inconsistent with used and reserved");

  // one item in flight
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in progress");

endmodule

bind page_bitmap_allocator_unit pba_checker u_pba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .cfg_wdata_i   (cfg_wdata_i),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
